### hw/rtl/nsop_pkg.sv
`timescale 1ns / 1ps
package nsop_pkg;

  localparam int DEF_MAX_POINTS = 1024;

  localparam int IDX_W   = 10;
  localparam int CNT_W   = 11;
  localparam int ANG_W   = 17;
  localparam int DIV_BITS = 17;
  localparam int SQRT_BITS = 17;
  localparam int TAYLOR_TERMS = 7;

  localparam int COS_STAGES = 4 + 3 * TAYLOR_TERMS;
  localparam int SHP_STAGES = SQRT_BITS + 8;
  localparam int LATENCY = 1 + DIV_BITS + COS_STAGES + SHP_STAGES + 1;

  localparam int TAYLOR_DIV [TAYLOR_TERMS] = '{182, 132, 90, 56, 30, 12, 2};

  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic signed [34:0] ONE_Q30 = 35'sd1073741824;

  localparam logic [31:0]        C_SQRT = 32'd1275175790;
  localparam logic signed [33:0] C_X1   = 34'sd541165879;
  localparam logic signed [33:0] C_X2   = 34'sd1510110501;
  localparam logic signed [33:0] C_X3   = 34'sd1221059202;
  localparam logic signed [33:0] C_X4   = 34'sd435939181;

  localparam logic [1:0] REG_POINT_COUNT = 2'd0;
  localparam logic [1:0] REG_CHORD       = 2'd1;
  localparam logic [1:0] REG_THICKNESS   = 2'd2;
  localparam logic [1:0] REG_GAP         = 2'd3;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    logic             err;
    logic             last;
  } tag_t;

endpackage

### hw/rtl/nsop_div.sv
`timescale 1ns / 1ps
module nsop_div
  import nsop_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  tag_t             tag_in,
  input  logic [CNT_W-1:0] segs,
  output tag_t             tag_out,
  output logic [ANG_W-1:0] angle
);

  localparam int NW = IDX_W + ANG_W + 1;
  localparam int DW = CNT_W + 1;

  tag_t                tg  [DIV_BITS+1];
  logic [NW-1:0]       rem [DIV_BITS+1];
  logic [DW-1:0]       den [DIV_BITS+1];
  logic [DIV_BITS-1:0] quo [DIV_BITS+1];

  assign tg[0]  = tag_in;
  assign rem[0] = {1'b0, tag_in.idx, {ANG_W{1'b0}}} + NW'(segs);
  assign den[0] = {segs, 1'b0};
  assign quo[0] = '0;

  for (genvar i = 0; i < DIV_BITS; i++) begin : g_bit
    localparam int B = DIV_BITS - 1 - i;
    logic [NW-1:0] comp;
    logic          take;

    assign comp = NW'(den[i]) << B;
    assign take = rem[i] >= comp;

    always_ff @(posedge clk) begin
      tg[i+1]  <= tg[i];
      den[i+1] <= den[i];
      rem[i+1] <= take ? rem[i] - comp : rem[i];
      quo[i+1] <= take ? quo[i] | (DIV_BITS'(1) << B) : quo[i];
      if (rst) begin
        tg[i+1].valid <= 1'b0;
      end
    end
  end

  assign tag_out = tg[DIV_BITS];
  assign angle   = (quo[DIV_BITS] > ANG_W'(65536)) ? ANG_W'(65536) : ANG_W'(quo[DIV_BITS]);

endmodule

### hw/rtl/nsop_cos.sv
`timescale 1ns / 1ps
module nsop_cos
  import nsop_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  tag_t             tag_in,
  input  logic [ANG_W-1:0] angle,
  input  logic [15:0]      gap,
  output tag_t             tag_out,
  output logic [16:0]      x_out
);

  tag_t        g0, g1, g2;
  logic        m0, m1, m2;
  logic [47:0] th_prod;
  logic [63:0] th_sq;
  logic [31:0] t2;
  logic        mirror;
  logic [16:0] am;
  logic [48:0] th_sum;
  logic [31:0] th;
  logic [63:0] t_sum;

  assign mirror = angle > ANG_W'(32768);
  assign am     = mirror ? ANG_W'(65536) - angle : angle;
  assign th_sum = {1'b0, th_prod} + 49'd32768;
  assign th     = th_sum[47:16];
  assign t_sum  = th_sq + 64'd536870912;

  always_ff @(posedge clk) begin
    g0      <= tag_in;
    m0      <= mirror;
    th_prod <= am[15:0] * PI_Q30;
    g1      <= g0;
    m1      <= m0;
    th_sq   <= th * th;
    g2      <= g1;
    m2      <= m1;
    t2      <= t_sum[61:30];
    if (rst) begin
      g0.valid <= 1'b0;
      g1.valid <= 1'b0;
      g2.valid <= 1'b0;
    end
  end

  tag_t                 tg  [TAYLOR_TERMS+1];
  logic                 mir [TAYLOR_TERMS+1];
  logic [31:0]          tt  [TAYLOR_TERMS+1];
  logic signed [34:0]   hh  [TAYLOR_TERMS+1];

  assign tg[0]  = g2;
  assign mir[0] = m2;
  assign tt[0]  = t2;
  assign hh[0]  = ONE_Q30;

  for (genvar k = 0; k < TAYLOR_TERMS; k++) begin : g_term
    localparam int D = TAYLOR_DIV[k];
    localparam logic [33:0] MREC = 34'((64'd1 << 34) / 64'(D));

    tag_t               sg1, sg2;
    logic               sm1, sm2, sn1, sn2;
    logic [31:0]        st1, st2;
    logic [63:0]        prd;
    logic [33:0]        qv;
    logic [67:0]        qm;
    logic signed [34:0] hneg;
    logic [31:0]        habs;
    logic [33:0]        qe, rr, qc;
    logic signed [34:0] qs;

    assign hneg = -hh[k];
    assign habs = hh[k][34] ? hneg[31:0] : hh[k][31:0];
    assign qe   = qm[67:34];
    assign rr   = qv - qe * 34'(D);
    assign qc   = (rr >= 34'(D)) ? qe + 34'd1 : qe;
    assign qs   = sn2 ? -$signed({1'b0, qc}) : $signed({1'b0, qc});

    always_ff @(posedge clk) begin
      sg1 <= tg[k];
      sm1 <= mir[k];
      st1 <= tt[k];
      sn1 <= hh[k][34];
      prd <= tt[k] * habs;
      sg2 <= sg1;
      sm2 <= sm1;
      st2 <= st1;
      sn2 <= sn1;
      qv  <= prd[63:30];
      qm  <= prd[63:30] * MREC;
      tg[k+1]  <= sg2;
      mir[k+1] <= sm2;
      tt[k+1]  <= st2;
      hh[k+1]  <= ONE_Q30 - qs;
      if (rst) begin
        sg1.valid     <= 1'b0;
        sg2.valid     <= 1'b0;
        tg[k+1].valid <= 1'b0;
      end
    end
  end

  logic [31:0] cl, vv, vr;
  logic signed [34:0] hf;

  assign hf = hh[TAYLOR_TERMS];
  assign cl = hf[34] ? 32'd0 : ((hf > ONE_Q30) ? 32'(ONE_Q30) : hf[31:0]);
  assign vv = mir[TAYLOR_TERMS] ? 32'(ONE_Q30) + cl : 32'(ONE_Q30) - cl;
  assign vr = vv + 32'd16384;

  always_ff @(posedge clk) begin
    tag_out <= tg[TAYLOR_TERMS];
    x_out   <= tg[TAYLOR_TERMS].last ? 17'd65536 - {1'b0, gap} : vr[31:15];
    if (rst) begin
      tag_out.valid <= 1'b0;
    end
  end

endmodule

### hw/rtl/nsop_shape.sv
`timescale 1ns / 1ps
module nsop_shape
  import nsop_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  tag_t        tag_in,
  input  logic [16:0] x_in,
  input  logic [14:0] thick,
  input  logic [31:0] chord,
  output tag_t        tag_out,
  output logic [31:0] x_coord,
  output logic [31:0] y_up
);

  function automatic logic signed [33:0] trunc16(input logic signed [49:0] v);
    logic signed [49:0] adj;
    adj = v + (v[49] ? 50'sd65535 : 50'sd0);
    return 34'(adj >>> 16);
  endfunction

  function automatic logic signed [33:0] poly_coef(input int i);
    logic signed [33:0] c;
    unique case (i)
      1:       c = C_X3;
      2:       c = -C_X2;
      default: c = -C_X1;
    endcase
    return c;
  endfunction

  tag_t               tg  [SQRT_BITS+1];
  logic [16:0]        xv  [SQRT_BITS+1];
  logic [16:0]        res [SQRT_BITS+1];
  logic [35:0]        sq  [SQRT_BITS+1];
  logic signed [49:0] acc [SQRT_BITS+1];

  assign tg[0]  = tag_in;
  assign xv[0]  = x_in;
  assign res[0] = '0;
  assign sq[0]  = '0;
  assign acc[0] = '0;

  for (genvar i = 0; i < SQRT_BITS; i++) begin : g_stage
    localparam int B = SQRT_BITS - 1 - i;
    logic [35:0]        trial;
    logic               take;
    logic signed [17:0] xs;
    logic signed [33:0] pp;
    logic signed [49:0] acc_next;

    assign trial = sq[i] + (36'(res[i]) << (B + 1)) + (36'd1 << (2 * B));
    assign take  = trial <= {3'd0, xv[i], 16'd0};
    assign xs    = $signed({1'b0, xv[i]});

    if (i == 0) begin : g_p0
      assign pp       = -C_X4;
      assign acc_next = pp * xs;
    end else if (i <= 3) begin : g_pm
      assign pp       = poly_coef(i) + trunc16(acc[i]);
      assign acc_next = pp * xs;
    end else if (i == 4) begin : g_pt
      assign pp       = trunc16(acc[i]);
      assign acc_next = 50'(pp);
    end else begin : g_ph
      assign pp       = acc[i][33:0];
      assign acc_next = 50'(pp);
    end

    always_ff @(posedge clk) begin
      tg[i+1]  <= tg[i];
      xv[i+1]  <= xv[i];
      res[i+1] <= take ? res[i] | (17'd1 << B) : res[i];
      sq[i+1]  <= take ? trial : sq[i];
      acc[i+1] <= acc_next;
      if (rst) begin
        tg[i+1].valid <= 1'b0;
      end
    end
  end

  localparam logic [29:0] M5  = 30'd858993459;
  localparam logic [18:0] MS5 = 19'd419431;

  tag_t               g1, g2, g3, g4, g5, g6, g7;
  logic [16:0]        x1, x2, x3, x4, x5, x6;
  logic [47:0]        m5;
  logic signed [33:0] p1;
  logic [31:0]        f2, f3;
  logic [61:0]        fm3;
  logic [29:0]        qf4;
  logic [2:0]         r4;
  logic [44:0]        a5;
  logic [17:0]        v5;
  logic [35:0]        yt6;
  logic [51:0]        yh7, yl7;
  logic [48:0]        xc7;

  logic signed [35:0] fsum;
  logic [29:0]        qe;
  logic [31:0]        rf;
  logic [36:0]        vs;
  logic [45:0]        ysum6;
  logic [52:0]        ysum7;

  assign fsum  = $signed({4'd0, m5[47:16]}) + 36'(p1);
  assign qe    = fm3[61:32];
  assign rf    = f3 - 32'(qe) * 32'd5;
  assign vs    = v5 * MS5;
  assign ysum6 = 46'(a5) + 46'(vs[36:21]);
  assign ysum7 = 53'(yh7) + 53'(yl7[51:16]);

  always_ff @(posedge clk) begin
    g1  <= tg[SQRT_BITS];
    x1  <= xv[SQRT_BITS];
    m5  <= res[SQRT_BITS] * C_SQRT;
    p1  <= acc[SQRT_BITS][33:0];
    g2  <= g1;
    x2  <= x1;
    f2  <= fsum[35] ? 32'd0 : fsum[31:0];
    g3  <= g2;
    x3  <= x2;
    f3  <= f2;
    fm3 <= f2 * M5;
    g4  <= g3;
    x4  <= x3;
    qf4 <= (rf >= 32'd5) ? qe + 30'd1 : qe;
    r4  <= (rf >= 32'd5) ? 3'(rf - 32'd5) : rf[2:0];
    g5  <= g4;
    x5  <= x4;
    a5  <= thick * qf4;
    v5  <= thick * r4;
    g6  <= g5;
    x6  <= x5;
    yt6 <= ysum6[45:10];
    g7  <= g6;
    yh7 <= yt6 * chord[31:16];
    yl7 <= yt6 * chord[15:0];
    xc7 <= x6 * chord;
    tag_out <= g7;
    x_coord <= xc7[47:16];
    y_up    <= (ysum7[52:48] != 5'd0) ? 32'hFFFF_FFFF : ysum7[47:16];
    if (rst) begin
      g1.valid      <= 1'b0;
      g2.valid      <= 1'b0;
      g3.valid      <= 1'b0;
      g4.valid      <= 1'b0;
      g5.valid      <= 1'b0;
      g6.valid      <= 1'b0;
      g7.valid      <= 1'b0;
      tag_out.valid <= 1'b0;
    end
  end

endmodule

### hw/rtl/naca_section_offset_points.sv
`timescale 1ns / 1ps
// Each accepted start transfer yields a done strobe at the end of the pipeline.
// Throughput: one point per cycle; busy is low whenever reset is low.
// The pipeline delay comes from the bit-per-stage angle divider, the seven-term cosine series
// and the bit-per-stage square root, each a run of pipeline registers.
// Reset empties the pipeline and loads the register defaults; results cannot be stalled.
module naca_section_offset_points
  import nsop_pkg::*;
#(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [IDX_W-1:0]   point_index,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               done,
  output logic [IDX_W-1:0]   point_index_echo,
  output logic [31:0]        x_coord,
  output logic [31:0]        y_upper,
  output logic signed [32:0] y_lower,
  output logic               index_error
);

  logic [CNT_W-1:0] pt_count;
  logic [31:0]      chord;
  logic [14:0]      thick;
  logic [15:0]      gap;

  assign busy      = rst;
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_count <= CNT_W'(2);
      chord    <= 32'd65536;
      thick    <= 15'd0;
      gap      <= 16'd131;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_POINT_COUNT: pt_count <= cfg_data[CNT_W-1:0];
        REG_CHORD:       chord    <= cfg_data;
        REG_THICKNESS:   thick    <= cfg_data[14:0];
        REG_GAP:         gap      <= cfg_data[15:0];
      endcase
    end
  end

  logic [CNT_W-1:0] count_eff, segs;
  tag_t             ent, div_tag, cos_tag, shp_tag;
  logic [ANG_W-1:0] angle;
  logic [16:0]      x_val;
  logic [31:0]      xc, yu;

  assign count_eff = (32'(pt_count) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : pt_count;
  assign segs      = count_eff - CNT_W'(1);

  always_ff @(posedge clk) begin
    ent.valid <= start && !busy;
    ent.idx   <= point_index;
    ent.err   <= (count_eff < CNT_W'(2)) || ({1'b0, point_index} >= count_eff);
    ent.last  <= {1'b0, point_index} == segs;
    if (rst) begin
      ent.valid <= 1'b0;
    end
  end

  nsop_div u_div (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (ent),
    .segs    (segs),
    .tag_out (div_tag),
    .angle   (angle)
  );

  nsop_cos u_cos (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (div_tag),
    .angle   (angle),
    .gap     (gap),
    .tag_out (cos_tag),
    .x_out   (x_val)
  );

  nsop_shape u_shape (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (cos_tag),
    .x_in    (x_val),
    .thick   (thick),
    .chord   (chord),
    .tag_out (shp_tag),
    .x_coord (xc),
    .y_up    (yu)
  );

  always_ff @(posedge clk) begin
    done             <= shp_tag.valid;
    point_index_echo <= shp_tag.idx;
    index_error      <= shp_tag.err;
    x_coord          <= shp_tag.err ? 32'd0 : xc;
    y_upper          <= shp_tag.err ? 32'd0 : yu;
    y_lower          <= shp_tag.err ? 33'sd0 : $signed(33'd0 - {1'b0, yu});
    if (rst) begin
      done <= 1'b0;
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("done strobe missing after transfer");

  a_echo: assert property (@(posedge clk) disable iff (rst)
    done |-> point_index_echo == $past(point_index, LATENCY))
    else $error("echoed index out of order");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && index_error |-> x_coord == 32'd0 && y_upper == 32'd0 && y_lower == 33'sd0)
    else $error("error result carries coordinates");

  a_lower: assert property (@(posedge clk) disable iff (rst)
    done && !index_error |-> y_lower == $signed(33'd0 - {1'b0, y_upper}))
    else $error("lower surface not the negation of upper");

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import nsop_pkg::*;

  localparam int IDLE_LIMIT = 4000;

  typedef struct {
    logic [IDX_W-1:0]   idx;
    logic [31:0]        x;
    logic [31:0]        yu;
    logic signed [32:0] yl;
    logic               err;
  } offset_pt_t;

  typedef enum logic {ROW_POINT, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e  kind;
    logic [1:0] reg_sel;
    logic [31:0] value;
    logic       typed;
    offset_pt_t want;
  } stim_row_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic [IDX_W-1:0] point_index = '0;
  logic cfg_valid = 0;
  logic [1:0] cfg_index = REG_POINT_COUNT;
  logic [31:0] cfg_data = '0;
  logic busy, cfg_ready, done, index_error;
  logic [IDX_W-1:0] point_index_echo;
  logic [31:0] x_coord, y_upper;
  logic signed [32:0] y_lower;

  logic [10:0] m_count;
  logic [31:0] m_chord;
  logic [14:0] m_thick;
  logic [15:0] m_gap;

  offset_pt_t pending_pts[$];
  stim_row_t  directed[$];
  int errors = 0;
  int idle_cycles = 0;

  naca_section_offset_points dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .point_index(point_index),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .point_index_echo(point_index_echo),
    .x_coord(x_coord), .y_upper(y_upper), .y_lower(y_lower), .index_error(index_error)
  );

  always #5 clk = ~clk;

  function automatic longint cos_q30(longint unsigned a);
    longint dv[7] = '{182, 132, 90, 56, 30, 12, 2};
    longint one = longint'(1) << 30;
    longint unsigned th, t;
    longint h;
    th = (a * 64'd3373259426 + 64'd32768) >> 16;
    t = (th * th + (64'd1 << 29)) >> 30;
    h = one;
    for (int i = 0; i < 7; i++) h = one - (longint'(t) * h) / (dv[i] * one);
    if (h < 0) h = 0;
    if (h > one) h = one;
    return h;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic offset_pt_t section_point(logic [IDX_W-1:0] idx);
    offset_pt_t o;
    longint unsigned cnt, segs, a, x, s, yt, y;
    longint v, p, f, one;
    one = longint'(1) << 30;
    cnt = (m_count > 1024) ? 1024 : m_count;
    o.idx = idx;
    o.x = '0; o.yu = '0; o.yl = '0; o.err = 1'b1;
    if (cnt < 2 || idx >= cnt) return o;
    segs = cnt - 1;
    if (idx == segs) begin
      x = 65536 - m_gap;
    end else begin
      a = (longint'(idx) * 131072 + segs) / (2 * segs);
      if (a > 65536) a = 65536;
      v = (a <= 32768) ? one - cos_q30(a) : one + cos_q30(65536 - a);
      x = (longint'(v) + (64'd1 << 14)) >> 15;
    end
    s = floor_sqrt(x << 16);
    p = 64'sd1221059202 - (64'sd435939181 * longint'(x)) / 65536;
    p = -64'sd1510110501 + (p * longint'(x)) / 65536;
    p = -64'sd541165879 + (p * longint'(x)) / 65536;
    p = (p * longint'(x)) / 65536;
    f = (64'sd1275175790 * longint'(s)) / 65536 + p;
    if (f < 0) f = 0;
    yt = (longint'(m_thick) * f) / 5120;
    y = (yt * m_chord[31:16] + ((yt * m_chord[15:0]) >> 16)) >> 16;
    if (y > 64'hFFFF_FFFF) y = 64'hFFFF_FFFF;
    o.x = 32'((x * m_chord) >> 16);
    o.yu = y[31:0];
    o.yl = 33'd0 - {1'b0, y[31:0]};
    o.err = 1'b0;
    return o;
  endfunction

  task automatic write_reg(logic [1:0] sel, logic [31:0] value);
    while (pending_pts.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (sel)
      REG_POINT_COUNT: m_count = value[10:0];
      REG_CHORD:       m_chord = value;
      REG_THICKNESS:   m_thick = value[14:0];
      REG_GAP:         m_gap = value[15:0];
    endcase
    @(posedge clk);
  endtask

  function automatic int gap_len(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_point(logic [IDX_W-1:0] idx, bit typed, offset_pt_t want, int gap,
                            bit last);
    start <= 1'b1;
    point_index <= idx;
    do @(posedge clk); while (busy);
    pending_pts.push_back(typed ? want : section_point(idx));
    if (last || gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic add_point(logic [IDX_W-1:0] idx, bit typed, logic [31:0] x, bit err);
    stim_row_t r;
    r.kind = ROW_POINT; r.reg_sel = REG_POINT_COUNT; r.value = 32'(idx); r.typed = typed;
    r.want.idx = idx; r.want.x = x; r.want.yu = '0; r.want.yl = '0; r.want.err = err;
    directed.push_back(r);
  endtask

  task automatic add_write(logic [1:0] sel, logic [31:0] value);
    stim_row_t r;
    r.kind = ROW_WRITE; r.reg_sel = sel; r.value = value; r.typed = 0;
    r.want = '{default: '0};
    directed.push_back(r);
  endtask

  always @(posedge clk) begin
    offset_pt_t w;
    if (!rst && done) begin
      if (pending_pts.size() == 0) begin
        $display("%0t: unexpected point idx %0d", $time, point_index_echo);
        errors++;
      end else begin
        w = pending_pts.pop_front();
        if (w.idx !== point_index_echo || w.x !== x_coord || w.yu !== y_upper ||
            w.yl !== y_lower || w.err !== index_error) begin
          $display("%0t: mismatch exp idx %0d x %h yu %h yl %h err %b", $time,
                   w.idx, w.x, w.yu, w.yl, w.err);
          $display("%0t:          got idx %0d x %h yu %h yl %h err %b", $time,
                   point_index_echo, x_coord, y_upper, y_lower, index_error);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[naca_section_offset_points] ERROR");
        $finish;
      end
    end
  end

  initial begin
    offset_pt_t none;
    int eff, n, sel;
    bit calm;
    logic [IDX_W-1:0] idx;
    none = '{default: '0};
    m_count = 2; m_chord = 32'd65536; m_thick = '0; m_gap = 16'd131;

    add_point(0, 1, 0, 0);
    add_point(1, 1, 65405, 0);
    add_point(2, 1, 0, 1);
    add_point(1023, 1, 0, 1);
    add_write(REG_POINT_COUNT, 0);
    add_point(0, 1, 0, 1);
    add_write(REG_POINT_COUNT, 32'h0000_07FF);
    add_write(REG_GAP, 0);
    add_write(REG_THICKNESS, 25600);
    add_write(REG_CHORD, 32'hFFFF_FFFF);
    add_point(0, 0, 0, 0);
    add_point(1023, 0, 0, 0);
    add_point(512, 0, 0, 0);
    add_point(1, 0, 0, 0);
    add_write(REG_THICKNESS, 32'hFFFF_FFFF);
    add_write(REG_CHORD, 0);
    add_point(700, 0, 0, 0);
    add_write(REG_POINT_COUNT, 3);
    add_write(REG_CHORD, 32'd65536);
    add_write(REG_THICKNESS, 1200);
    add_write(REG_GAP, 16'hFFFF);
    add_point(0, 0, 0, 0);
    add_point(1, 0, 0, 0);
    add_point(2, 0, 0, 0);
    add_point(3, 0, 0, 0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_WRITE)
        write_reg(directed[i].reg_sel, directed[i].value);
      else
        send_point(directed[i].value[IDX_W-1:0], directed[i].typed, directed[i].want,
                   gap_len(0),
                   (i == directed.size() - 1) || (directed[i+1].kind == ROW_WRITE));
    end

    for (int ph = 0; ph < 8; ph++) begin
      sel = $urandom_range(0, 5);
      case (sel)
        0: write_reg(REG_POINT_COUNT, $urandom_range(0, 1));
        1: write_reg(REG_POINT_COUNT, $urandom_range(1025, 2047));
        2: write_reg(REG_POINT_COUNT, $urandom_range(2, 1024));
        default: write_reg(REG_POINT_COUNT, $urandom_range(2, 40));
      endcase
      sel = $urandom_range(0, 3);
      write_reg(REG_CHORD, sel == 0 ? 32'hFFFF_FFFF : sel == 1 ? $urandom_range(0, 1 << 22)
                                                           : $urandom());
      sel = $urandom_range(0, 3);
      write_reg(REG_THICKNESS, sel == 0 ? 32'd25600 : sel == 1 ? $urandom()
                                                             : $urandom_range(0, 3000));
      sel = $urandom_range(0, 3);
      write_reg(REG_GAP, sel == 0 ? 32'd0 : sel == 1 ? 32'hFFFF : $urandom_range(0, 600));
      eff = (m_count > 1024) ? 1024 : m_count;
      calm = ($urandom_range(0, 3) == 0);
      n = 60;
      for (int k = 0; k < n; k++) begin
        sel = $urandom_range(0, 99);
        if (eff >= 2 && sel < 15) idx = IDX_W'(eff - 1);
        else if (eff >= 2 && sel < 85) idx = IDX_W'($urandom_range(0, eff - 1));
        else idx = IDX_W'($urandom_range(0, 1023));
        send_point(idx, 0, none, gap_len(calm), k == n - 1);
      end
    end

    while (pending_pts.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0)
      $display("[naca_section_offset_points] OK");
    else
      $display("[naca_section_offset_points] ERROR");
    $finish;
  end

endmodule
